/* rtl/core/fmrwl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the register code table of the FM register write logger.
// No dependencies; every other file of the block imports this package.
package fmrwl_pkg;

    localparam int ADDR_W       = 9;
    localparam int BYTE_W       = 8;
    localparam int TIME_W       = 32;
    localparam int SHADOW_DEPTH = 512;
    localparam int CNT_W        = 2;
    localparam int MAX_RES      = 3;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;

    // Configuration register index (byte address 4 * index).
    localparam logic REG_RESTART_GAP = 1'b0;

    localparam logic [TIME_W-1:0] GAP_RESET   = 32'd30000;
    localparam logic [TIME_W-1:0] SHORT_LIMIT = 32'd257;

    localparam logic [BYTE_W-1:0] DELAY_SHORT_CODE = 8'd122;
    localparam logic [BYTE_W-1:0] DELAY_LONG_CODE  = 8'd123;

    localparam logic [ADDR_W-1:0] ADDR_FOUR_OP  = 9'h104;
    localparam logic [ADDR_W-1:0] ADDR_FOUR_EN  = 9'h105;
    localparam logic [ADDR_W-1:0] ADDR_DUAL_LO  = 9'h1b0;
    localparam logic [ADDR_W-1:0] ADDR_DUAL_HI  = 9'h1b8;
    localparam logic [BYTE_W-1:0] KEY_LO        = 8'hb0;
    localparam logic [BYTE_W-1:0] KEY_HI        = 8'hb8;
    localparam logic [BYTE_W-1:0] KEY_ON_BIT    = 8'h20;
    localparam logic [BYTE_W-1:0] PERC_ADDR     = 8'hbd;
    localparam logic [BYTE_W-1:0] PERC_MASK     = 8'h3f;
    localparam logic [BYTE_W-1:0] PERC_MIN      = 8'h20;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_STOP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_START = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_DUAL   = 2'd1,
        MODE_FOUR   = 2'd2
    } mode_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] reg_addr;
        logic [BYTE_W-1:0] reg_value;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] code;
        logic [BYTE_W-1:0] data;
        mode_t             hw_mode;
        logic [TIME_W-1:0] total_ms;
        logic [TIME_W-1:0] total_pairs;
    } res_t;

    // Group of results handed from the evaluation stage to the output queue.
    typedef struct packed {
        logic                   en;
        logic [CNT_W-1:0]       cnt;
        res_t [MAX_RES-1:0]     res;
    } load_t;

    // Write-back request into the shadow memory.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] val;
    } shw_t;

    typedef struct packed {
        logic       hit;
        logic [6:0] code;
    } code_t;

    // Maps a low register address to its 7-bit code; hit is low for unmapped registers.
    function automatic code_t code_for(logic [7:0] r);
        code_t      c;
        logic [2:0] top;
        logic [4:0] idx;
        logic [2:0] grp;
        logic [4:0] slot;
        logic [3:0] ch;
        logic [1:0] grp2;
        c    = '0;
        top  = r[7:5];
        idx  = r[4:0];
        grp  = (top == 3'd7) ? 3'd4 : 3'(top - 3'd1);
        slot = 5'(int'(idx[4:3]) * 6 + int'(idx[2:0]));
        ch   = r[3:0];
        grp2 = 2'(r[7:4] - 4'ha);
        case (r)
            8'h01: c = '{hit: 1'b1, code: 7'd0};
            8'h04: c = '{hit: 1'b1, code: 7'd1};
            8'h05: c = '{hit: 1'b1, code: 7'd2};
            8'h08: c = '{hit: 1'b1, code: 7'd3};
            8'hbd: c = '{hit: 1'b1, code: 7'd4};
            default:
            begin
                if ((top >= 3'd1 && top <= 3'd4) || top == 3'd7)
                begin
                    if (idx < 5'd24 && idx[2:0] < 3'd6)
                    begin
                        c.hit  = 1'b1;
                        c.code = 7'(5 + int'(slot) * 5 + int'(grp));
                    end
                end
                else if (r >= 8'ha0 && r <= 8'hc8 && ch <= 4'd8)
                begin
                    c.hit  = 1'b1;
                    c.code = 7'(95 + int'(ch) * 3 + int'(grp2));
                end
            end
        endcase
        return c;
    endfunction

    // Hardware mode after a logged write; nz_four_en is the old shadow of 0x105 being nonzero.
    function automatic mode_t mode_after(mode_t m, logic [ADDR_W-1:0] addr,
                                         logic [BYTE_W-1:0] val, logic nz_four_en);
        mode_t r;
        r = m;
        if (r != MODE_FOUR && addr == ADDR_FOUR_OP && val != '0 && nz_four_en)
            r = MODE_FOUR;
        if (r == MODE_SINGLE && addr >= ADDR_DUAL_LO && addr <= ADDR_DUAL_HI && val != '0)
            r = MODE_DUAL;
        return r;
    endfunction

endpackage

/* rtl/core/fmrwl_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result streams of the logger.
// Depends on fmrwl_pkg for field widths and enum types.
interface fmrwl_req_if import fmrwl_pkg::*; ();
    logic              valid;
    logic              ready;
    op_t               op;
    logic [ADDR_W-1:0] reg_addr;
    logic [BYTE_W-1:0] reg_value;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, op, reg_addr, reg_value, now_ms, input ready);
    modport sink   (input valid, op, reg_addr, reg_value, now_ms, output ready);
endinterface

interface fmrwl_rsp_if import fmrwl_pkg::*; ();
    logic              valid;
    logic              ready;
    kind_t             kind;
    logic [BYTE_W-1:0] code;
    logic [BYTE_W-1:0] data;
    mode_t             hw_mode;
    logic [TIME_W-1:0] total_ms;
    logic [TIME_W-1:0] total_pairs;
    logic              last;

    modport source (output valid, kind, code, data, hw_mode, total_ms, total_pairs, last,
                    input ready);
    modport sink   (input valid, kind, code, data, hw_mode, total_ms, total_pairs, last,
                    output ready);
endinterface

/* rtl/core/fmrwl_cfg.sv */
`timescale 1ns / 1ps
// APB-style configuration register file holding the restart gap limit.
// Depends on fmrwl_pkg.
module fmrwl_cfg import fmrwl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [TIME_W-1:0]     gap
);

    logic [TIME_W-1:0] gap_reg;
    logic              hit;

    // Bits 1:0 are the byte offset; bit 2 selects the register.
    assign hit    = paddr[2] == REG_RESTART_GAP;
    assign pready = 1'b1;
    assign prdata = hit ? gap_reg : '0;
    assign gap    = gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= GAP_RESET;
        else if (psel && penable && pwrite && pready && hit)
            gap_reg <= pwdata;
    end

endmodule

/* rtl/core/fmrwl_shadow.sv */
`timescale 1ns / 1ps
// Shadow register memory: 512 x 8 single-port-write RAM with registered read,
// write-to-read forwarding and a clearing sweep after reset. Depends on fmrwl_pkg.
module fmrwl_shadow import fmrwl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  shw_t              wr,
    output logic [BYTE_W-1:0] old_val,
    output logic              clr_done
);

    logic [BYTE_W-1:0] mem [SHADOW_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;
    logic              hit_reg;
    logic [BYTE_W-1:0] hit_val_reg;
    logic [ADDR_W:0]   clr_cnt_reg;

    assign clr_done = clr_cnt_reg[ADDR_W];
    assign old_val  = hit_reg ? hit_val_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (!clr_done)
            mem[clr_cnt_reg[ADDR_W-1:0]] <= '0;
        else if (wr.en)
            mem[wr.addr] <= wr.val;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
        if (rd_en)
            hit_val_reg <= wr.val;
    end

    // A read issued in the same cycle as a write to the same entry sees the old word,
    // so the written byte is kept aside and used instead.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg     <= 1'b0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (!clr_done)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (rd_en)
                hit_reg <= wr.en && wr.addr == rd_addr;
        end
    end

endmodule

/* rtl/core/fmrwl_core.sv */
`timescale 1ns / 1ps
// Evaluation stage: holds one request, compares it with the shadow byte, keeps the
// stream state and produces up to three results per request. Depends on fmrwl_pkg.
module fmrwl_core import fmrwl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  item_t             item,
    input  logic [BYTE_W-1:0] old_val,
    input  logic [TIME_W-1:0] gap,
    input  logic              can_load,
    output logic              free,
    output shw_t              shw,
    output load_t             load
);

    logic              s1_valid_reg;
    item_t             s1_reg;
    logic              cap_reg,  cap_next;
    logic [TIME_W-1:0] lt_reg,   lt_next;
    logic [TIME_W-1:0] ms_reg,   ms_next;
    logic [TIME_W-1:0] pc_reg,   pc_next;
    mode_t             mode_reg, mode_next;
    logic              nz_four_reg;
    logic              adv;

    logic [CNT_W-1:0]   n_v;
    res_t [MAX_RES-1:0] res_v;
    code_t              cv;
    logic [TIME_W-1:0]  passed;
    logic               idle;
    logic               trig;
    logic [BYTE_W-1:0]  lo;

    function automatic res_t mk(kind_t k, logic [BYTE_W-1:0] c, logic [BYTE_W-1:0] d,
                                mode_t m, logic [TIME_W-1:0] ms, logic [TIME_W-1:0] pc);
        res_t r;
        r.kind        = k;
        r.code        = c;
        r.data        = d;
        r.hw_mode     = m;
        r.total_ms    = ms;
        r.total_pairs = pc;
        return r;
    endfunction

    always_comb
    begin
        lo        = s1_reg.reg_addr[BYTE_W-1:0];
        cv        = code_for(lo);
        passed    = s1_reg.now_ms - lt_reg;
        trig      = (lo >= KEY_LO && lo <= KEY_HI && (s1_reg.reg_value & KEY_ON_BIT) != '0)
                 || (lo == PERC_ADDR && (s1_reg.reg_value & PERC_MASK) > PERC_MIN);
        cap_next  = cap_reg;
        lt_next   = lt_reg;
        ms_next   = ms_reg;
        pc_next   = pc_reg;
        mode_next = mode_reg;
        n_v       = '0;
        res_v     = '0;
        idle      = !cap_reg;
        if (s1_reg.op == OP_STOP)
        begin
            if (cap_reg)
            begin
                cap_next = 1'b0;
                res_v[n_v] = mk(KIND_END, '0, '0, mode_next, ms_next, pc_next);
                n_v = n_v + 1'b1;
            end
        end
        else
        begin
            if (cap_reg && cv.hit && old_val != s1_reg.reg_value)
            begin
                lt_next = s1_reg.now_ms;
                ms_next = ms_reg + passed;
                if (passed > gap)
                begin
                    cap_next = 1'b0;
                    idle     = 1'b1;
                    res_v[n_v] = mk(KIND_END, '0, '0, mode_next, ms_next, pc_next);
                    n_v = n_v + 1'b1;
                end
                else
                begin
                    if (passed != '0)
                    begin
                        if (passed < SHORT_LIMIT)
                        begin
                            pc_next = pc_next + 1'b1;
                            res_v[n_v] = mk(KIND_PAIR, DELAY_SHORT_CODE,
                                            passed[BYTE_W-1:0] - 1'b1,
                                            mode_next, ms_next, pc_next);
                            n_v = n_v + 1'b1;
                        end
                        else
                        begin
                            // Multiples above 256 saturate; the excess only shows in total_ms.
                            pc_next = pc_next + 1'b1;
                            res_v[n_v] = mk(KIND_PAIR, DELAY_LONG_CODE,
                                            (passed[TIME_W-1:16] != '0) ? 8'hff
                                                : passed[15:8] - 1'b1,
                                            mode_next, ms_next, pc_next);
                            n_v = n_v + 1'b1;
                            if (passed[BYTE_W-1:0] != '0)
                            begin
                                pc_next = pc_next + 1'b1;
                                res_v[n_v] = mk(KIND_PAIR, DELAY_SHORT_CODE,
                                                passed[BYTE_W-1:0] - 1'b1,
                                                mode_next, ms_next, pc_next);
                                n_v = n_v + 1'b1;
                            end
                        end
                    end
                    mode_next = mode_after(mode_next, s1_reg.reg_addr, s1_reg.reg_value,
                                           nz_four_reg);
                    pc_next = pc_next + 1'b1;
                    res_v[n_v] = mk(KIND_PAIR, {s1_reg.reg_addr[ADDR_W-1], cv.code},
                                    s1_reg.reg_value, mode_next, ms_next, pc_next);
                    n_v = n_v + 1'b1;
                end
            end
            if (idle && trig)
            begin
                cap_next  = 1'b1;
                ms_next   = '0;
                pc_next   = '0;
                lt_next   = s1_reg.now_ms;
                res_v[n_v] = mk(KIND_START, '0, '0, MODE_SINGLE, ms_next, pc_next);
                n_v = n_v + 1'b1;
                mode_next = mode_after(MODE_SINGLE, s1_reg.reg_addr, s1_reg.reg_value,
                                       nz_four_reg);
                if (cv.hit)
                begin
                    pc_next = pc_next + 1'b1;
                    res_v[n_v] = mk(KIND_PAIR, {s1_reg.reg_addr[ADDR_W-1], cv.code},
                                    s1_reg.reg_value, mode_next, ms_next, pc_next);
                    n_v = n_v + 1'b1;
                end
            end
        end
    end

    // A request that yields nothing leaves at once; otherwise it waits for the queue.
    assign adv  = s1_valid_reg && (n_v == '0 || can_load);
    assign free = !s1_valid_reg || adv;

    assign shw.en   = adv && s1_reg.op == OP_WRITE;
    assign shw.addr = s1_reg.reg_addr;
    assign shw.val  = s1_reg.reg_value;

    assign load.en  = adv && n_v != '0;
    assign load.cnt = n_v;
    assign load.res = res_v;

    always_ff @(posedge clk)
    begin
        if (take)
            s1_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            cap_reg      <= 1'b0;
            lt_reg       <= '0;
            ms_reg       <= '0;
            pc_reg       <= '0;
            mode_reg     <= MODE_SINGLE;
            nz_four_reg  <= 1'b0;
        end
        else
        begin
            if (take)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;
            if (adv)
            begin
                cap_reg  <= cap_next;
                lt_reg   <= lt_next;
                ms_reg   <= ms_next;
                pc_reg   <= pc_next;
                mode_reg <= mode_next;
                if (shw.en && s1_reg.reg_addr == ADDR_FOUR_EN)
                    nz_four_reg <= s1_reg.reg_value != '0;
            end
        end
    end

endmodule

/* rtl/core/fmrwl_emit.sv */
`timescale 1ns / 1ps
// Output queue: holds the results of one request and hands them out one per
// handshake, marking the last. Depends on fmrwl_pkg and the result interface.
module fmrwl_emit import fmrwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  load_t       load,
    output logic        can_load,
    fmrwl_rsp_if.source rsp
);

    res_t [MAX_RES-1:0] res_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               shift;

    assign rsp.valid       = cnt_reg != '0;
    assign rsp.kind        = res_reg[0].kind;
    assign rsp.code        = res_reg[0].code;
    assign rsp.data        = res_reg[0].data;
    assign rsp.hw_mode     = res_reg[0].hw_mode;
    assign rsp.total_ms    = res_reg[0].total_ms;
    assign rsp.total_pairs = res_reg[0].total_pairs;
    assign rsp.last        = cnt_reg == CNT_W'(1);

    assign shift    = rsp.valid && rsp.ready;
    assign can_load = cnt_reg == '0 || (shift && rsp.last);

    always_ff @(posedge clk)
    begin
        if (load.en)
            res_reg <= load.res;
        else if (shift)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (load.en)
            cnt_reg <= load.cnt;
        else if (shift)
            cnt_reg <= cnt_reg - 1'b1;
    end

endmodule

/* rtl/core/fm_register_write_logger.sv */
`timescale 1ns / 1ps
// FM register write logger. An accepted request and its shadow byte are registered; its
// results then pass into the output queue registers. Throughput: one request per cycle
// while each yields at most one result and rsp is ready; a request with several results
// holds the single result port until all are handed out. Reset: asynchronous; then a
// sweep clears the shadow memory, req.ready low; configuration writes are still taken.
module fm_register_write_logger import fmrwl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    fmrwl_req_if.sink             req,
    fmrwl_rsp_if.source           rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // The design is a two-step pipeline around the shadow memory. At the accept edge the
    // shadow byte of the addressed register is read; in the following cycle the core
    // compares it with the new byte and, once the queue can take its results, updates
    // the registered stream state, writes the byte back and hands up to three results to
    // the queue. A same-edge write-back and read of one entry are resolved by forwarding
    // in the shadow RAM, so requests may follow in every cycle while the queue keeps up.

    logic              take;
    logic              core_free;
    logic              clr_done;
    logic              can_load;
    logic [BYTE_W-1:0] old_val;
    logic [TIME_W-1:0] gap;
    item_t             item;
    shw_t              shw;
    load_t             load;

    assign req.ready = clr_done && core_free;
    assign take      = req.valid && req.ready;

    assign item.op        = req.op;
    assign item.reg_addr  = req.reg_addr;
    assign item.reg_value = req.reg_value;
    assign item.now_ms    = req.now_ms;

    fmrwl_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gap     (gap)
    );

    // Shadow memory: read port driven by the accepted request, write port by the core.
    fmrwl_shadow u_shadow
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (take),
        .rd_addr  (req.reg_addr),
        .wr       (shw),
        .old_val  (old_val),
        .clr_done (clr_done)
    );

    // Decision logic and stream state; it accepts a new request whenever its current
    // one moves on, which may be the same cycle.
    fmrwl_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .item     (item),
        .old_val  (old_val),
        .gap      (gap),
        .can_load (can_load),
        .free     (core_free),
        .shw      (shw),
        .load     (load)
    );

    // Result queue that separates the core from back pressure on the result channel.
    fmrwl_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .can_load (can_load),
        .rsp      (rsp)
    );

endmodule
